>>> rtl/core/cwa_pkg.sv
`default_nettype none
package cwa_pkg;

   localparam int STEP_BITS  = 12;
   localparam int OUT_BITS   = 14;
   localparam int INDEX_BITS = 3;

   typedef enum logic [INDEX_BITS-1:0] {
      CSR_MODE       = 3'd0,
      CSR_POS_STEP_X = 3'd1,
      CSR_POS_STEP_Y = 3'd2,
      CSR_SIZE_STEP_X = 3'd3,
      CSR_SIZE_STEP_Y = 3'd4,
      CSR_FRAME_W    = 3'd5,
      CSR_FRAME_H    = 3'd6,
      CSR_UNUSED     = 3'd7
   } csr_index_type;

   localparam logic [STEP_BITS-1:0] POS_STEP_RESET  = 12'd1;
   localparam logic [STEP_BITS-1:0] SIZE_STEP_RESET = 12'd1;
   localparam logic [STEP_BITS-1:0] FRAME_W_RESET   = 12'd640;
   localparam logic [STEP_BITS-1:0] FRAME_H_RESET   = 12'd480;

endpackage
`default_nettype wire

>>> rtl/core/cwa_rem_pipe.sv
`default_nettype none
module cwa_rem_pipe #(
   parameter int NUM_BITS  = 12,
   parameter int SIDE_BITS = 1
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               in_valid,
   input  wire logic [NUM_BITS-1:0]                in_num,
   input  wire logic [cwa_pkg::STEP_BITS-1:0]      in_div,
   input  wire logic [SIDE_BITS-1:0]               in_side,
   output logic                                    out_valid,
   output logic [cwa_pkg::STEP_BITS-1:0]           out_rem,
   output logic [SIDE_BITS-1:0]                    out_side
);

   localparam int SB = cwa_pkg::STEP_BITS;

   logic [NUM_BITS:0]   valid_w;
   logic [SB-1:0]       rem_w  [NUM_BITS+1];
   logic [NUM_BITS-1:0] num_w  [NUM_BITS+1];
   logic [SIDE_BITS-1:0] side_w [NUM_BITS+1];

   assign valid_w[0] = in_valid;
   assign rem_w[0]   = '0;
   assign num_w[0]   = in_num;
   assign side_w[0]  = in_side;

   // restoring remainder, one dividend bit per stage
   for (genvar k = 0; k < NUM_BITS; k++) begin : g_stage
      logic [SB:0]          trial;
      logic [SB:0]          diff;
      logic [SB-1:0]        rem_in;
      logic                 valid_ff;
      logic [SB-1:0]        rem_ff;
      logic [NUM_BITS-1:0]  num_ff;
      logic [SIDE_BITS-1:0] side_ff;

      always_comb begin
         trial  = {rem_w[k], num_w[k][NUM_BITS-1-k]};
         diff   = trial - {1'b0, in_div};
         rem_in = (trial >= {1'b0, in_div}) ? diff[SB-1:0] : trial[SB-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else begin
            valid_ff <= valid_w[k];
         end
         rem_ff  <= rem_in;
         num_ff  <= num_w[k];
         side_ff <= side_w[k];
      end

      assign valid_w[k+1] = valid_ff;
      assign rem_w[k+1]   = rem_ff;
      assign num_w[k+1]   = num_ff;
      assign side_w[k+1]  = side_ff;
   end

   assign out_valid = valid_w[NUM_BITS];
   assign out_rem   = rem_w[NUM_BITS];
   assign out_side  = side_w[NUM_BITS];

endmodule
`default_nettype wire

>>> rtl/core/cwa_axis.sv
`default_nettype none
module cwa_axis #(
   parameter int COORD_BITS = 12
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               in_valid,
   input  wire logic [COORD_BITS-1:0]              a,
   input  wire logic [COORD_BITS-1:0]              b,
   input  wire logic [cwa_pkg::STEP_BITS-1:0]      pos_step,
   input  wire logic [cwa_pkg::STEP_BITS-1:0]      size_step,
   input  wire logic [cwa_pkg::STEP_BITS-1:0]      frame,
   input  wire logic                               recentre,
   input  wire logic                               mode_on,
   output logic                                    out_valid,
   output logic signed [cwa_pkg::OUT_BITS-1:0]     origin,
   output logic signed [cwa_pkg::OUT_BITS-1:0]     extent
);

   localparam int CB = COORD_BITS;
   localparam int SB = cwa_pkg::STEP_BITS;
   localparam int OB = cwa_pkg::OUT_BITS;
   localparam int MX = (CB > SB) ? CB : SB;
   localparam int EW = MX + 1;
   localparam int MB = MX + 2;
   localparam int WW = MX + 4;

   // origin remainder
   logic          va;
   logic [SB-1:0] ra;
   logic [2*CB-1:0] sa;

   cwa_rem_pipe #(.NUM_BITS(CB), .SIDE_BITS(2*CB)) u_rem_org (
      .clock, .reset,
      .in_valid(in_valid), .in_num(a), .in_div(pos_step), .in_side({a, b}),
      .out_valid(va), .out_rem(ra), .out_side(sa)
   );

   logic signed [WW-1:0] a_s, b_s, ra_s, p_s, d_s;
   logic                 v1_ff;
   logic [CB-1:0]        a1_ff, b1_ff, p1_ff;
   logic signed [WW-1:0] d1_ff;

   always_comb begin
      a_s  = WW'(sa[2*CB-1:CB]);
      b_s  = WW'(sa[CB-1:0]);
      ra_s = WW'(ra);
      p_s  = a_s - ra_s;
      d_s  = b_s - p_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= va;
      end
      a1_ff <= sa[2*CB-1:CB];
      b1_ff <= sa[CB-1:0];
      p1_ff <= p_s[CB-1:0];
      d1_ff <= d_s;
   end

   // extent remainder
   logic          d_pos;
   logic [CB-1:0] d_num;
   logic          vb;
   logic [SB-1:0] rb;
   logic [3*CB:0] sb_side;

   assign d_pos = (d1_ff > 0);
   assign d_num = d_pos ? d1_ff[CB-1:0] : '0;

   cwa_rem_pipe #(.NUM_BITS(CB), .SIDE_BITS(3*CB+1)) u_rem_ext (
      .clock, .reset,
      .in_valid(v1_ff), .in_num(d_num), .in_div(size_step),
      .in_side({a1_ff, b1_ff, p1_ff, d_pos}),
      .out_valid(vb), .out_rem(rb), .out_side(sb_side)
   );

   logic signed [WW-1:0] a2_s, b2_s, p2_s, d2_s, ss_s, rb_s, e_s, h_s, half_s, mv_s;
   logic                 v2_ff;
   logic [CB-1:0]        a2_ff, b2_ff, p2_ff;
   logic [EW-1:0]        e2_ff;
   logic signed [WW-1:0] mv2_ff;

   always_comb begin
      a2_s = WW'(sb_side[3*CB:2*CB+1]);
      b2_s = WW'(sb_side[2*CB:CB+1]);
      p2_s = WW'(sb_side[CB:1]);
      ss_s = WW'(size_step);
      rb_s = WW'(rb);
      d2_s = b2_s - p2_s;
      if (!sb_side[0]) begin
         e_s = ss_s;
      end else if (rb != '0) begin
         e_s = d2_s + ss_s - rb_s;
      end else begin
         e_s = d2_s;
      end
      h_s    = b2_s - a2_s;
      half_s = (h_s + $signed(WW'(h_s[WW-1]))) >>> 1;
      mv_s   = half_s + a2_s - p2_s - (e_s >>> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= vb;
      end
      a2_ff  <= sb_side[3*CB:2*CB+1];
      b2_ff  <= sb_side[2*CB:CB+1];
      p2_ff  <= sb_side[CB:1];
      e2_ff  <= e_s[EW-1:0];
      mv2_ff <= mv_s;
   end

   // recentre move remainder
   logic                 mv_neg;
   logic signed [WW-1:0] mv_abs;
   logic                 vc;
   logic [SB-1:0]        rc;
   logic [MB+3*CB+EW:0]  sc;

   assign mv_neg = mv2_ff[WW-1];
   assign mv_abs = mv_neg ? -mv2_ff : mv2_ff;

   cwa_rem_pipe #(.NUM_BITS(MB), .SIDE_BITS(MB+3*CB+EW+1)) u_rem_mv (
      .clock, .reset,
      .in_valid(v2_ff), .in_num(mv_abs[MB-1:0]), .in_div(pos_step),
      .in_side({mv_abs[MB-1:0], a2_ff, b2_ff, p2_ff, e2_ff, mv_neg}),
      .out_valid(vc), .out_rem(rc), .out_side(sc)
   );

   logic signed [WW-1:0] a3_s, b3_s, p3_s, e3_s, q_s, mvq_s, fr_s, org_s;
   logic [MB-1:0]        mag;
   logic                 v3_ff;
   logic [OB-1:0]        org_ff, ext_ff;

   always_comb begin
      a3_s = WW'(sc[3*CB+EW:2*CB+EW+1]);
      b3_s = WW'(sc[2*CB+EW:CB+EW+1]);
      p3_s = WW'(sc[CB+EW:EW+1]);
      e3_s = WW'(sc[EW:1]);
      fr_s = WW'(frame);
      mag  = sc[MB+3*CB+EW:3*CB+EW+1];
      q_s  = WW'(mag) - WW'(rc);
      mvq_s = sc[0] ? -q_s : q_s;
      org_s = recentre ? (p3_s + mvq_s) : p3_s;
      if (org_s < 0) begin
         org_s = '0;
      end
      if (org_s + e3_s - WW'(1) > fr_s) begin
         org_s = fr_s - e3_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= vc;
      end
      if (mode_on) begin
         org_ff <= org_s[OB-1:0];
         ext_ff <= e3_s[OB-1:0];
      end else begin
         org_ff <= a3_s[OB-1:0];
         ext_ff <= 14'(b3_s - a3_s);
      end
   end

   assign out_valid = v3_ff;
   assign origin    = org_ff;
   assign extent    = ext_ff;

endmodule
`default_nettype wire

>>> rtl/core/crop_window_aligner.sv
`default_nettype none
// Crop window aligner. Takes the two corners of a selection and returns an
// aligned sensor window. A request is taken in every cycle (busy stays low);
// its result appears with rsp_valid after it has passed through three
// bit-per-stage remainder pipelines in series (origin step, extent step,
// recentre move). Results cannot be held off.
// Register writes are taken at once and must only be made while no request
// is in flight.
module crop_window_aligner #(
   parameter int COORD_BITS = 12
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic [COORD_BITS-1:0]                 req_corner_a_x,
   input  wire logic [COORD_BITS-1:0]                 req_corner_a_y,
   input  wire logic [COORD_BITS-1:0]                 req_corner_b_x,
   input  wire logic [COORD_BITS-1:0]                 req_corner_b_y,
   output logic                                       rsp_valid,
   output logic signed [cwa_pkg::OUT_BITS-1:0]        rsp_origin_x,
   output logic signed [cwa_pkg::OUT_BITS-1:0]        rsp_origin_y,
   output logic signed [cwa_pkg::OUT_BITS-1:0]        rsp_extent_x,
   output logic signed [cwa_pkg::OUT_BITS-1:0]        rsp_extent_y,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [cwa_pkg::INDEX_BITS-1:0]        csr_index,
   input  wire logic [cwa_pkg::STEP_BITS-1:0]         csr_data
);

   localparam int SB = cwa_pkg::STEP_BITS;

   logic          mode_ff;
   logic [SB-1:0] psx_ff, psy_ff, ssx_ff, ssy_ff, fw_ff, fh_ff;
   logic [SB-1:0] psx, psy, ssx, ssy;
   logic          recentre;
   logic          accept;
   logic          vx, vy;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         psx_ff  <= cwa_pkg::POS_STEP_RESET;
         psy_ff  <= cwa_pkg::POS_STEP_RESET;
         ssx_ff  <= cwa_pkg::SIZE_STEP_RESET;
         ssy_ff  <= cwa_pkg::SIZE_STEP_RESET;
         fw_ff   <= cwa_pkg::FRAME_W_RESET;
         fh_ff   <= cwa_pkg::FRAME_H_RESET;
      end else if (csr_valid && csr_ready) begin
         case (cwa_pkg::csr_index_type'(csr_index))
            cwa_pkg::CSR_MODE:        mode_ff <= csr_data[0];
            cwa_pkg::CSR_POS_STEP_X:  psx_ff  <= csr_data;
            cwa_pkg::CSR_POS_STEP_Y:  psy_ff  <= csr_data;
            cwa_pkg::CSR_SIZE_STEP_X: ssx_ff  <= csr_data;
            cwa_pkg::CSR_SIZE_STEP_Y: ssy_ff  <= csr_data;
            cwa_pkg::CSR_FRAME_W:     fw_ff   <= csr_data;
            cwa_pkg::CSR_FRAME_H:     fh_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // zero step reads as one
   assign psx = (psx_ff == '0) ? SB'(1) : psx_ff;
   assign psy = (psy_ff == '0) ? SB'(1) : psy_ff;
   assign ssx = (ssx_ff == '0) ? SB'(1) : ssx_ff;
   assign ssy = (ssy_ff == '0) ? SB'(1) : ssy_ff;
   assign recentre = (psx < ssx) || (psy < ssy);

   cwa_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
      .clock, .reset, .in_valid(accept),
      .a(req_corner_a_x), .b(req_corner_b_x),
      .pos_step(psx), .size_step(ssx), .frame(fw_ff),
      .recentre(recentre), .mode_on(mode_ff),
      .out_valid(vx), .origin(rsp_origin_x), .extent(rsp_extent_x)
   );

   cwa_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
      .clock, .reset, .in_valid(accept),
      .a(req_corner_a_y), .b(req_corner_b_y),
      .pos_step(psy), .size_step(ssy), .frame(fh_ff),
      .recentre(recentre), .mode_on(mode_ff),
      .out_valid(vy), .origin(rsp_origin_y), .extent(rsp_extent_y)
   );

   assign rsp_valid = vx && vy;

endmodule
`default_nettype wire

>>> rtl/core/cwa_checker.sv
`default_nettype none
module cwa_checker #(
   parameter int COORD_BITS = 12
) (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               start,
   input wire logic                               busy,
   input wire logic                               rsp_valid,
   input wire logic                               csr_valid,
   input wire logic                               csr_ready
);

   localparam int MX  = (COORD_BITS > cwa_pkg::STEP_BITS) ? COORD_BITS : cwa_pkg::STEP_BITS;
   localparam int LAT = 2 * COORD_BITS + MX + 5;

   a_no_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("response missing");

   a_rsp_caused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("response without request");

   a_csr_taken: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

endmodule

bind crop_window_aligner cwa_checker #(.COORD_BITS(COORD_BITS)) u_cwa_checker (
   .clock, .reset, .start, .busy, .rsp_valid, .csr_valid, .csr_ready
);
`default_nettype wire

>>> tb/crop_window_aligner_checker.sv
`timescale 1ns / 100ps
module crop_window_aligner_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic                              busy,
   input  wire logic [11:0]                       req_corner_a_x,
   input  wire logic [11:0]                       req_corner_a_y,
   input  wire logic [11:0]                       req_corner_b_x,
   input  wire logic [11:0]                       req_corner_b_y,
   input  wire logic                              rsp_valid,
   input  wire logic signed [cwa_pkg::OUT_BITS-1:0] rsp_origin_x,
   input  wire logic signed [cwa_pkg::OUT_BITS-1:0] rsp_origin_y,
   input  wire logic signed [cwa_pkg::OUT_BITS-1:0] rsp_extent_x,
   input  wire logic signed [cwa_pkg::OUT_BITS-1:0] rsp_extent_y,
   input  wire logic                              csr_valid,
   input  wire logic                              csr_ready,
   input  wire logic [cwa_pkg::INDEX_BITS-1:0]    csr_index,
   input  wire logic [cwa_pkg::STEP_BITS-1:0]     csr_data,
   output int                                     window_errors,
   output int                                     windows_pending
);
   import cwa_pkg::*;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] org_x;
      logic signed [OUT_BITS-1:0] org_y;
      logic signed [OUT_BITS-1:0] ext_x;
      logic signed [OUT_BITS-1:0] ext_y;
   } crop_window_t;

   crop_window_t expected_windows[$];

   logic                 mode_on;
   logic [STEP_BITS-1:0] pstep_x, pstep_y, sstep_x, sstep_y, frame_w, frame_h;

   function automatic int step_or_one(logic [STEP_BITS-1:0] s);
      return (s == 0) ? 1 : int'(s);
   endfunction

   function automatic void fit_axis(input int a, input int b, input int ps, input int ss,
                                    input bit recentre, input int frame,
                                    output int org, output int ext);
      int p, e, r, mv;
      p = a - (a % ps);
      e = b - p;
      if (e <= 0) begin
         e = ss;
      end else begin
         r = e % ss;
         if (r > 0) e = e + ss - r;
      end
      if (recentre) begin
         mv = (b - a) / 2 + a - (p + e / 2);
         mv = (mv / ps) * ps;
         p = p + mv;
      end
      if (p < 0) p = 0;
      if (p + e - 1 > frame) p = frame - e;
      org = p;
      ext = e;
   endfunction

   function automatic crop_window_t predict_window(int ax, int ay, int bx, int by);
      crop_window_t w;
      int ox, oy, ex, ey, psx, psy, ssx, ssy;
      bit rc;
      if (mode_on) begin
         psx = step_or_one(pstep_x);
         psy = step_or_one(pstep_y);
         ssx = step_or_one(sstep_x);
         ssy = step_or_one(sstep_y);
         rc = (psx < ssx) || (psy < ssy);
         fit_axis(ax, bx, psx, ssx, rc, int'(frame_w), ox, ex);
         fit_axis(ay, by, psy, ssy, rc, int'(frame_h), oy, ey);
      end else begin
         ox = ax;
         oy = ay;
         ex = bx - ax;
         ey = by - ay;
      end
      w.org_x = ox[OUT_BITS-1:0];
      w.org_y = oy[OUT_BITS-1:0];
      w.ext_x = ex[OUT_BITS-1:0];
      w.ext_y = ey[OUT_BITS-1:0];
      return w;
   endfunction

   assign windows_pending = expected_windows.size();

   always @(posedge clock) begin
      crop_window_t exp_w;
      if (reset) begin
         mode_on <= 1'b0;
         pstep_x <= POS_STEP_RESET;
         pstep_y <= POS_STEP_RESET;
         sstep_x <= SIZE_STEP_RESET;
         sstep_y <= SIZE_STEP_RESET;
         frame_w <= FRAME_W_RESET;
         frame_h <= FRAME_H_RESET;
         expected_windows.delete();
         window_errors <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_MODE:        mode_on <= csr_data[0];
               CSR_POS_STEP_X:  pstep_x <= csr_data;
               CSR_POS_STEP_Y:  pstep_y <= csr_data;
               CSR_SIZE_STEP_X: sstep_x <= csr_data;
               CSR_SIZE_STEP_Y: sstep_y <= csr_data;
               CSR_FRAME_W:     frame_w <= csr_data;
               CSR_FRAME_H:     frame_h <= csr_data;
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (expected_windows.size() == 0) begin
               if (window_errors < 10)
                  $display("unexpected window transfer: %0d %0d %0d %0d",
                           rsp_origin_x, rsp_origin_y, rsp_extent_x, rsp_extent_y);
               window_errors <= window_errors + 1;
            end else begin
               exp_w = expected_windows.pop_front();
               if (exp_w.org_x !== rsp_origin_x || exp_w.org_y !== rsp_origin_y ||
                   exp_w.ext_x !== rsp_extent_x || exp_w.ext_y !== rsp_extent_y) begin
                  if (window_errors < 10)
                     $display("window mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                              exp_w.org_x, exp_w.org_y, exp_w.ext_x, exp_w.ext_y,
                              rsp_origin_x, rsp_origin_y, rsp_extent_x, rsp_extent_y);
                  window_errors <= window_errors + 1;
               end
            end
         end
         if (start && !busy)
            expected_windows.push_back(predict_window(int'(req_corner_a_x),
               int'(req_corner_a_y), int'(req_corner_b_x), int'(req_corner_b_y)));
      end
   end
endmodule

>>> tb/tb_crop_window_aligner.sv
`timescale 1ns / 100ps
module tb_crop_window_aligner;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [11:0] req_corner_a_x = '0, req_corner_a_y = '0;
   logic [11:0] req_corner_b_x = '0, req_corner_b_y = '0;
   logic rsp_valid;
   logic signed [cwa_pkg::OUT_BITS-1:0] rsp_origin_x, rsp_origin_y;
   logic signed [cwa_pkg::OUT_BITS-1:0] rsp_extent_x, rsp_extent_y;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [cwa_pkg::INDEX_BITS-1:0] csr_index = '0;
   logic [cwa_pkg::STEP_BITS-1:0] csr_data = '0;
   int window_errors, windows_pending;
   int idle_pct;
   int frame_w_now, frame_h_now;

   always #5 clock = ~clock;

   crop_window_aligner uut (.*);
   crop_window_aligner_checker checker_i (.*);

   // leaves csr_valid high; the caller drops it after the last write
   task automatic write_csr(cwa_pkg::csr_index_type idx, int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[cwa_pkg::STEP_BITS-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_mode(int mode, int psx, int psy, int ssx, int ssy, int fw, int fh);
      wait (windows_pending == 0);
      repeat (50) @(posedge clock);
      write_csr(cwa_pkg::CSR_MODE, mode);
      write_csr(cwa_pkg::CSR_POS_STEP_X, psx);
      write_csr(cwa_pkg::CSR_POS_STEP_Y, psy);
      write_csr(cwa_pkg::CSR_SIZE_STEP_X, ssx);
      write_csr(cwa_pkg::CSR_SIZE_STEP_Y, ssy);
      write_csr(cwa_pkg::CSR_FRAME_W, fw);
      write_csr(cwa_pkg::CSR_FRAME_H, fh);
      write_csr(cwa_pkg::CSR_UNUSED, $urandom);
      csr_valid <= 1'b0;
      frame_w_now = fw;
      frame_h_now = fh;
   endtask

   task automatic send_window(int ax, int ay, int bx, int by);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_corner_a_x <= ax[11:0];
      req_corner_a_y <= ay[11:0];
      req_corner_b_x <= bx[11:0];
      req_corner_b_y <= by[11:0];
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic int near_coord(int lim);
      return $urandom_range(0, (lim > 4095) ? 4095 : lim);
   endfunction

   task automatic random_windows(int n);
      int ax, ay, bx, by;
      repeat (n) begin
         if ($urandom_range(1)) begin
            ax = $urandom_range(4095); ay = $urandom_range(4095);
            bx = $urandom_range(4095); by = $urandom_range(4095);
         end else begin
            ax = near_coord(frame_w_now); ay = near_coord(frame_h_now);
            bx = ax + $urandom_range(0, 400) - (($urandom_range(9) == 0) ? 500 : 0);
            by = ay + $urandom_range(0, 400) - (($urandom_range(9) == 0) ? 500 : 0);
            if (bx < 0) bx = 0;
            if (by < 0) by = 0;
            if (bx > 4095) bx = 4095;
            if (by > 4095) by = 4095;
         end
         send_window(ax, ay, bx, by);
      end
      start <= 1'b0;
   endtask

   task automatic directed_windows();
      send_window(0, 0, 0, 0);
      send_window(4095, 4095, 4095, 4095);
      send_window(0, 0, 4095, 4095);
      send_window(4095, 4095, 0, 0);
      send_window(100, 50, 300, 250);
      send_window(2730, 1365, 1365, 2730);
      send_window(600, 440, 660, 500);
      start <= 1'b0;
   endtask

   initial begin
      frame_w_now = 640;
      frame_h_now = 480;
      idle_pct = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_windows();
      set_mode(1, 16, 8, 64, 32, 640, 480);
      directed_windows();
      set_mode(1, 0, 0, 0, 0, 640, 480);
      directed_windows();
      set_mode(1, 4095, 4095, 4095, 4095, 4095, 4095);
      directed_windows();
      set_mode(1, 64, 64, 8, 8, 1, 1);
      directed_windows();
      for (int ph = 0; ph < 8; ph++) begin
         idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 63 : 6);
         case (ph)
            0: set_mode(0, 1, 1, 1, 1, 640, 480);
            1: set_mode(1, 16, 8, 64, 32, 640, 480);
            2: set_mode(1, 4, 4, 4, 4, 1920, 1080);
            3: set_mode(1, 0, 4095, 0, 4095, 4095, 1);
            4: set_mode(1, 4095, 1, 1, 4095, 1, 4095);
            default: set_mode(1, $urandom_range(0, 100), $urandom_range(0, 100),
                              $urandom_range(0, 200), $urandom_range(0, 200),
                              $urandom_range(1, 4095), $urandom_range(1, 4095));
         endcase
         random_windows(135);
      end
      wait (windows_pending == 0);
      repeat (60) @(posedge clock);
      if (window_errors == 0)
         $display("crop_window_aligner regression: pass");
      else
         $display("crop_window_aligner regression: fail");
      $finish;
   end

   initial begin
      #3ms;
      $display("crop_window_aligner regression: fail");
      $finish;
   end
endmodule
